[hw/rtl/msc_pkg.sv]
// ----------------------------------------------------------------------------
// msc_pkg: shared types and codes for the MIPS subset core
// Item operation codes, instruction opcodes, ALU function codes and word types.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

    typedef logic [31:0] word_t;
    typedef logic [4:0]  reg_idx_t;
    typedef logic [1:0]  item_op_t;

    // item operations
    localparam item_op_t OP_EXEC     = 2'd0;
    localparam item_op_t OP_PRELOAD  = 2'd1;
    localparam item_op_t OP_READ_MEM = 2'd2;
    localparam item_op_t OP_READ_REG = 2'd3;

    // primary opcodes, instruction bits 31..26
    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_J     = 6'h02;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_ADDIU = 6'h09;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] OPC_SW    = 6'h2B;

    // R-type function, low three funct bits
    localparam logic [2:0] FN_ADDU = 3'd1;
    localparam logic [2:0] FN_SUBU = 3'd3;
    localparam logic [2:0] FN_AND  = 3'd4;
    localparam logic [2:0] FN_OR   = 3'd5;
    localparam logic [2:0] FN_NOR  = 3'd7;

    // halt instruction
    localparam word_t HALT_WORD = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

[hw/rtl/mips_subset_single_cycle_core.sv]
// ----------------------------------------------------------------------------
// mips_subset_single_cycle_core: MIPS subset core with preload and inspection
// Executes addu/subu/and/or/nor/addiu/lw/sw/beq/j/halt one beat at a time and
// gives access to data memory and the register file between instructions.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (s_*) carry either an instruction word for the pc last
//   reported in m_next_pc, or a memory preload, memory read or register read.
//   Each input beat yields exactly one result beat (m_*), in order.
//   A beat passes through the register read stage, then the result register.
//   Throughput: one beat per cycle unless m_ready low holds the result
//   register; register values produced by the previous beat, including lw
//   data, are bypassed so dependent instructions follow without a gap.
//   Data memory is four byte-wide banks of DMEM_BYTES/4 rows; a word access
//   at any byte address touches each bank once, so one memory access per beat
//   uses all banks together. DMEM_BYTES must be a power of two; not enforced.
//   Reset clears pc, halt flag, last ALU result and the register file; data
//   memory holds no defined value until written. No clearing pass is needed.
//   When m_ready is low the result register holds; one further beat is still
//   taken into the read stage before s_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_subset_single_cycle_core #(
    parameter int DMEM_BYTES = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire msc_pkg::item_op_t s_op,
    input  wire msc_pkg::word_t    s_instr,
    input  wire logic [11:0]       s_mem_addr,
    input  wire msc_pkg::word_t    s_mem_data,
    input  wire msc_pkg::reg_idx_t s_reg_index,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output msc_pkg::word_t         m_cur_pc,
    output msc_pkg::word_t         m_next_pc,
    output logic                   m_halted,
    output logic                   m_reg_write_en,
    output msc_pkg::reg_idx_t      m_reg_write_index,
    output msc_pkg::word_t         m_reg_write_value,
    output logic                   m_store_en,
    output msc_pkg::word_t         m_read_data
);
    import msc_pkg::*;

    localparam int AW   = $clog2(DMEM_BYTES);
    localparam int RW   = AW - 2;
    localparam int ROWS = DMEM_BYTES / 4;

    // handshake and stage occupancy
    logic     a_valid_reg, a_valid_next;
    logic     b_valid_reg, b_valid_next;
    logic     b_new_reg;
    logic     b_free, adv_a, accept;

    // architectural state
    word_t    pc_reg;
    logic     halt_reg;
    word_t    last_alu_reg;
    word_t    rf_mem [32];
    logic [31:0] rf_valid_reg;

    // read stage
    item_op_t    a_op_reg;
    word_t       a_instr_reg;
    logic [11:0] a_mem_addr_reg;
    word_t       a_mem_data_reg;
    reg_idx_t    a_idx_a_reg;
    word_t       rf_rd_a_reg, rf_rd_b_reg;
    logic        rf_vld_a_reg, rf_vld_b_reg;
    logic        ovr_a_vld_reg, ovr_b_vld_reg;
    word_t       ovr_a_reg, ovr_b_reg;
    reg_idx_t    s_idx_a;

    // result stage
    word_t    b_cur_pc_reg, b_npc_reg, b_wval_reg, b_rdata_reg;
    logic     b_halted_reg, b_we_reg, b_st_reg, b_load_reg, b_sel_mem_reg;
    reg_idx_t b_widx_reg;
    logic [1:0] b_off_reg;
    logic [7:0] mem_rd_reg [4];
    word_t    mem_word;

    // write-back
    logic     rf_we;
    word_t    wb_val;

    // execute decode
    word_t    opa, opb, sext, pc4, br_tgt, j_tgt, ea_sum;
    word_t    alu_res, npc, ea32;
    logic [5:0] opc;
    logic     run, halt_set, we, st, load, alu_upd;
    reg_idx_t widx;
    logic     mem_we, mem_re;
    word_t    mem_wdata;
    logic [AW-1:0] byte_addr;
    logic [RW-1:0] row;
    logic [1:0]    off;

    // ------------------------------------------------------------------
    // Handshake: advance the read stage whenever the result register frees
    // ------------------------------------------------------------------
    assign b_free  = !b_valid_reg || m_ready;
    assign adv_a   = a_valid_reg && b_free;
    assign s_ready = !a_valid_reg || b_free;
    assign accept  = s_valid && s_ready;
    assign m_valid = b_valid_reg;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (adv_a) begin
            a_valid_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        if (adv_a) begin
            b_valid_next = 1'b1;
        end else if (m_ready) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_new_reg   <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            b_new_reg   <= adv_a;
        end
    end

    // ------------------------------------------------------------------
    // Register file: write once per result beat, in its first cycle
    // ------------------------------------------------------------------
    assign rf_we  = b_new_reg && b_we_reg;
    assign wb_val = b_load_reg ? mem_word : b_wval_reg;
    assign s_idx_a = (s_op == OP_READ_REG) ? s_reg_index : s_instr[25:21];

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[b_widx_reg] <= wb_val;
        end
        if (accept) begin
            rf_rd_a_reg <= rf_mem[s_idx_a];
            rf_rd_b_reg <= rf_mem[s_instr[20:16]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
        end else if (rf_we) begin
            rf_valid_reg[b_widx_reg] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Read stage capture; track writes that land while the beat waits here
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_op_reg       <= s_op;
            a_instr_reg    <= s_instr;
            a_mem_addr_reg <= s_mem_addr;
            a_mem_data_reg <= s_mem_data;
            a_idx_a_reg    <= s_idx_a;
            rf_vld_a_reg   <= rf_valid_reg[s_idx_a];
            rf_vld_b_reg   <= rf_valid_reg[s_instr[20:16]];
            ovr_a_vld_reg  <= rf_we && (b_widx_reg == s_idx_a);
            ovr_b_vld_reg  <= rf_we && (b_widx_reg == s_instr[20:16]);
            ovr_a_reg      <= wb_val;
            ovr_b_reg      <= wb_val;
        end else begin
            if (rf_we && (b_widx_reg == a_idx_a_reg)) begin
                ovr_a_vld_reg <= 1'b1;
                ovr_a_reg     <= wb_val;
            end
            if (rf_we && (b_widx_reg == a_instr_reg[20:16])) begin
                ovr_b_vld_reg <= 1'b1;
                ovr_b_reg     <= wb_val;
            end
        end
    end

    // Pick the newest value: landing write, then tracked write, then file
    always_comb begin
        if (rf_we && (b_widx_reg == a_idx_a_reg)) begin
            opa = wb_val;
        end else if (ovr_a_vld_reg) begin
            opa = ovr_a_reg;
        end else begin
            opa = rf_vld_a_reg ? rf_rd_a_reg : '0;
        end
        if (rf_we && (b_widx_reg == a_instr_reg[20:16])) begin
            opb = wb_val;
        end else if (ovr_b_vld_reg) begin
            opb = ovr_b_reg;
        end else begin
            opb = rf_vld_b_reg ? rf_rd_b_reg : '0;
        end
    end

    // ------------------------------------------------------------------
    // Execute: decode, ALU, next pc
    // ------------------------------------------------------------------
    assign opc    = a_instr_reg[31:26];
    assign sext   = {{16{a_instr_reg[15]}}, a_instr_reg[15:0]};
    assign pc4    = pc_reg + 32'd4;
    assign br_tgt = pc4 + {sext[29:0], 2'b00};
    assign j_tgt  = {pc4[31:28], a_instr_reg[25:0], 2'b00};
    assign ea_sum = opa + sext;
    assign run    = (a_op_reg == OP_EXEC) && !halt_reg && (a_instr_reg != HALT_WORD);

    always_comb begin
        npc      = pc_reg;
        halt_set = 1'b0;
        we       = 1'b0;
        widx     = '0;
        st       = 1'b0;
        load     = 1'b0;
        alu_upd  = 1'b0;
        alu_res  = last_alu_reg;
        if ((a_op_reg == OP_EXEC) && !halt_reg && (a_instr_reg == HALT_WORD)) begin
            halt_set = 1'b1;
        end
        if (run) begin
            npc = pc4;
            unique case (opc)
                OPC_RTYPE: begin
                    we   = 1'b1;
                    widx = a_instr_reg[15:11];
                    unique case (a_instr_reg[2:0])
                        FN_ADDU: begin
                            alu_res = opa + opb;
                            alu_upd = 1'b1;
                        end
                        FN_SUBU: begin
                            alu_res = opa - opb;
                            alu_upd = 1'b1;
                        end
                        FN_AND: begin
                            alu_res = opa & opb;
                            alu_upd = 1'b1;
                        end
                        FN_OR: begin
                            alu_res = opa | opb;
                            alu_upd = 1'b1;
                        end
                        FN_NOR: begin
                            alu_res = ~(opa | opb);
                            alu_upd = 1'b1;
                        end
                        default: begin
                            alu_res = last_alu_reg;
                        end
                    endcase
                end
                OPC_ADDIU: begin
                    we      = 1'b1;
                    widx    = a_instr_reg[20:16];
                    alu_res = ea_sum;
                    alu_upd = 1'b1;
                end
                OPC_LW: begin
                    we      = 1'b1;
                    widx    = a_instr_reg[20:16];
                    load    = 1'b1;
                    alu_res = ea_sum;
                    alu_upd = 1'b1;
                end
                OPC_SW: begin
                    st      = 1'b1;
                    alu_res = ea_sum;
                    alu_upd = 1'b1;
                end
                OPC_BEQ: begin
                    if (opa == opb) begin
                        npc = br_tgt;
                    end
                end
                OPC_J: begin
                    npc = j_tgt;
                end
                default: begin
                    npc = pc4;
                end
            endcase
        end
    end

    // Architectural state moves with the beat leaving the read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            halt_reg     <= 1'b0;
            last_alu_reg <= '0;
        end else if (adv_a) begin
            pc_reg   <= npc;
            halt_reg <= halt_reg | halt_set;
            if (alu_upd) begin
                last_alu_reg <= alu_res;
            end
        end
    end

    // ------------------------------------------------------------------
    // Data memory: four byte banks, one row each per word access
    // ------------------------------------------------------------------
    assign ea32      = ((a_op_reg == OP_PRELOAD) || (a_op_reg == OP_READ_MEM)) ?
                       32'(a_mem_addr_reg) : alu_res;
    assign byte_addr = ea32[AW-1:0];
    assign row       = byte_addr[AW-1:2];
    assign off       = byte_addr[1:0];
    assign mem_we    = adv_a && ((a_op_reg == OP_PRELOAD) || st);
    assign mem_re    = adv_a && ((a_op_reg == OP_READ_MEM) || load);
    assign mem_wdata = (a_op_reg == OP_PRELOAD) ? a_mem_data_reg : opb;

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [RW-1:0] row_k;
        logic [1:0]    lane_k;
        logic [7:0]    wbyte_k;
        logic [7:0]    bank_mem [ROWS];

        // bytes below the start lane belong to the following row
        assign row_k   = (2'(k) < off) ? row + RW'(1) : row;
        assign lane_k  = 2'(k) - off;
        assign wbyte_k = 8'(mem_wdata >> {~lane_k, 3'b000});

        always_ff @(posedge aclk) begin
            if (mem_we) begin
                bank_mem[row_k] <= wbyte_k;
            end
            if (mem_re) begin
                mem_rd_reg[k] <= bank_mem[row_k];
            end
        end
    end

    // Reassemble the big-endian word from the rotated bank lanes
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mem_word[31-8*i -: 8] = mem_rd_reg[2'(b_off_reg + 2'(i))];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (adv_a) begin
            b_cur_pc_reg  <= pc_reg;
            b_npc_reg     <= npc;
            b_halted_reg  <= halt_reg | halt_set;
            b_we_reg      <= we;
            b_widx_reg    <= widx;
            b_wval_reg    <= we ? alu_res : '0;
            b_st_reg      <= st;
            b_load_reg    <= load;
            b_sel_mem_reg <= (a_op_reg == OP_READ_MEM) || load;
            b_rdata_reg   <= (a_op_reg == OP_READ_REG) ? opa : '0;
            b_off_reg     <= off;
        end
    end

    assign m_cur_pc          = b_cur_pc_reg;
    assign m_next_pc         = b_npc_reg;
    assign m_halted          = b_halted_reg;
    assign m_reg_write_en    = b_we_reg;
    assign m_reg_write_index = b_widx_reg;
    assign m_reg_write_value = wb_val;
    assign m_store_en        = b_st_reg;
    assign m_read_data       = b_sel_mem_reg ? mem_word : b_rdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // pc and halt flag always agree with the beat held in the result register
    a_pc_track: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (pc_reg == b_npc_reg))
        else $error("pc diverged from last reported next pc");

    a_halt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (halt_reg == b_halted_reg))
        else $error("halt flag diverged from last reported state");

    // once halted the pc is frozen
    a_halt_pc_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> $stable(pc_reg))
        else $error("pc moved while halted");

    // a beat that writes no register reports zero index and value
    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_reg_write_en) |->
            ((m_reg_write_index == '0) && (m_reg_write_value == '0)))
        else $error("write fields set without a register write");

    // input is refused only when both stages are full and the output stalls
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (a_valid_reg && b_valid_reg && !m_ready))
        else $error("input refused with room in the pipeline");

endmodule

`default_nettype wire
